### rtl/sbpq_pkg.sv
// ----------------------------------------------------------------------------
// sbpq_pkg
// shared constants, codes and controller/datapath structs for the queue
// ----------------------------------------------------------------------------
package sbpq_pkg;
    localparam int SLOT_BITS = 10;
    localparam int PRI_W    = 6;
    localparam int LOC_W    = 32;
    localparam int STAT_W   = 2;
    localparam int TOT_W    = 12;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

    localparam logic [1:0] ROLE_TOP = 2'd0;
    localparam logic [1:0] ROLE_MID = 2'd1;
    localparam logic [1:0] ROLE_BOT = 2'd2;

    typedef struct packed {
        logic load;
        logic push_do;
        logic slide_start;
        logic slide_skip;
        logic slide_fail;
        logic copy_step;
        logic pop_do;
        logic pop_cap;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic is_pop;
        logic need_slide;
        logic slide_ovf;
        logic slide_empty;
        logic copy_done;
        logic pop_hit;
    } t_stat;
endpackage

### rtl/sbpq_in_if.sv
// ----------------------------------------------------------------------------
// sbpq_in_if
// request channel: push or pop word with valid/ready
// ----------------------------------------------------------------------------
interface sbpq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [sbpq_pkg::PRI_W-1:0]  push_pri;
    logic [sbpq_pkg::LOC_W-1:0]  push_loc;

    modport source (output valid, mode, push_pri, push_loc, input ready);
    modport sink   (input valid, mode, push_pri, push_loc, output ready);
endinterface

### rtl/sbpq_out_if.sv
// ----------------------------------------------------------------------------
// sbpq_out_if
// result channel: one word per request with valid/ready
// ----------------------------------------------------------------------------
interface sbpq_out_if;
    logic                        valid;
    logic                        ready;
    logic                        pop_valid;
    logic [sbpq_pkg::PRI_W-1:0]  pop_pri;
    logic [sbpq_pkg::LOC_W-1:0]  pop_loc;
    logic [sbpq_pkg::STAT_W-1:0] status;
    logic [sbpq_pkg::TOT_W-1:0]  total_count;
    logic                        queue_empty;

    modport source (output valid, pop_valid, pop_pri, pop_loc, status, total_count,
                    queue_empty, input ready);
    modport sink   (input valid, pop_valid, pop_pri, pop_loc, status, total_count,
                    queue_empty, output ready);
endinterface

### rtl/sliding_bucket_priority_queue.sv
// ----------------------------------------------------------------------------
// sliding_bucket_priority_queue
// three-bucket sliding-window priority queue with push/pop request channel
// ----------------------------------------------------------------------------
// One request word is taken at a time and answered with exactly one result
// word. An in-window push passes from accept through dispatch to the result
// state; a pop passes through dispatch and the pop read, and when it
// delivers an item also through a capture state (one registered read of the
// item store). A push above the top priority adds, for every step of the
// window, a state to pick the merge, a copy of the items of the smaller
// bucket one by one (the store has a single read and a single write port)
// and a return to dispatch; a merge of an empty bucket skips the copy. The
// store is not cleared after reset: only entries that were written are
// ever used. The result sits in an output register, so a new request is
// taken while the previous result is still waiting for the sink.
// ----------------------------------------------------------------------------
module sliding_bucket_priority_queue #(
    parameter int SLOT_BITS = sbpq_pkg::SLOT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbpq_in_if.sink    i_in,
    sbpq_out_if.source o_out
);
    sbpq_pkg::t_cmd  cmd;
    sbpq_pkg::t_stat stat;

    // sequencer
    sbpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // bucket state, store and result word
    sbpq_dp #(.SLOT_BITS(SLOT_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (i_in.mode),
        .i_push_pri    (i_in.push_pri),
        .i_push_loc    (i_in.push_loc),
        .o_pop_valid   (o_out.pop_valid),
        .o_pop_pri     (o_out.pop_pri),
        .o_pop_loc     (o_out.pop_loc),
        .o_status      (o_out.status),
        .o_total_count (o_out.total_count),
        .o_queue_empty (o_out.queue_empty)
    );

    // a new result word never overwrites one the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out.valid || o_out.ready))
        else $error("result word overwritten");

    // datapath operations are mutually exclusive
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.push_do, cmd.slide_start, cmd.slide_skip,
                  cmd.slide_fail, cmd.copy_step, cmd.pop_do, cmd.pop_cap, cmd.emit}))
        else $error("overlapping datapath commands");

    // no result in the cycle right after a request is taken
    a_no_early_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !cmd.emit)
        else $error("result emitted too early");
endmodule

### rtl/sbpq_ram.sv
// ----------------------------------------------------------------------------
// sbpq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sbpq_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 3072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/sbpq_ctrl.sv
// ----------------------------------------------------------------------------
// sbpq_ctrl
// sequencer: dispatch, window slides with bucket copy, pop read, result hand-off
// ----------------------------------------------------------------------------
module sbpq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  sbpq_pkg::t_stat  i_stat,
    output sbpq_pkg::t_cmd   o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_SLIDE = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_POPD  = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_in_ready = 1'b0;
        n_ovalid   = r_ovalid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PUSH;
                end
            end
            S_PUSH: begin
                priority if (i_stat.is_pop) begin
                    n_state = S_POP;
                end else if (i_stat.need_slide) begin
                    n_state = S_SLIDE;
                end else begin
                    o_cmd.push_do = 1'b1;
                    n_state       = S_RES;
                end
            end
            S_SLIDE: begin
                priority if (i_stat.slide_ovf) begin
                    o_cmd.slide_fail = 1'b1;
                    n_state          = S_RES;
                end else if (i_stat.slide_empty) begin
                    o_cmd.slide_skip = 1'b1;
                    n_state          = S_PUSH;
                end else begin
                    o_cmd.slide_start = 1'b1;
                    n_state           = S_COPY;
                end
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_stat.copy_done) begin
                    n_state = S_PUSH;
                end
            end
            S_POP: begin
                o_cmd.pop_do = 1'b1;
                n_state      = i_stat.pop_hit ? S_POPD : S_RES;
            end
            S_POPD: begin
                o_cmd.pop_cap = 1'b1;
                n_state       = S_RES;
            end
            S_RES: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
endmodule

### rtl/sbpq_dp.sv
// ----------------------------------------------------------------------------
// sbpq_dp
// bucket bookkeeping, item store, slide copy engine and result registers
// ----------------------------------------------------------------------------
module sbpq_dp #(
    parameter int SLOT_BITS = sbpq_pkg::SLOT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sbpq_pkg::t_cmd              i_cmd,
    output sbpq_pkg::t_stat             o_stat,
    input  logic                        i_mode,
    input  logic [sbpq_pkg::PRI_W-1:0]  i_push_pri,
    input  logic [sbpq_pkg::LOC_W-1:0]  i_push_loc,
    output logic                        o_pop_valid,
    output logic [sbpq_pkg::PRI_W-1:0]  o_pop_pri,
    output logic [sbpq_pkg::LOC_W-1:0]  o_pop_loc,
    output logic [sbpq_pkg::STAT_W-1:0] o_status,
    output logic [sbpq_pkg::TOT_W-1:0]  o_total_count,
    output logic                        o_queue_empty
);
    localparam int CW   = SLOT_BITS + 1;
    localparam int AW   = SLOT_BITS + 2;
    localparam int SW   = SLOT_BITS + 3;
    localparam int IW   = sbpq_pkg::PRI_W + sbpq_pkg::LOC_W;
    localparam int PW   = sbpq_pkg::PRI_W;
    localparam int LW   = sbpq_pkg::LOC_W;
    localparam logic [CW-1:0] BCAP = {1'b1, {SLOT_BITS{1'b0}}};
    localparam int TOT_PAD = sbpq_pkg::TOT_W - 1;

    logic [SLOT_BITS-1:0] r_head [3];
    logic [CW-1:0]       r_cnt  [3];
    logic [1:0]          r_role [3];
    logic [PW-1:0]       r_top;
    logic                r_seen;

    logic                r_mode;
    logic [PW-1:0]       r_pri;
    logic [LW-1:0]       r_loc;

    logic                r_res_valid;
    logic [PW-1:0]       r_res_pri;
    logic [LW-1:0]       r_res_loc;
    logic [1:0]          r_res_status;

    logic [1:0]          r_cp_src, r_cp_dst;
    logic [SLOT_BITS-1:0] r_cp_sbase, r_cp_dbase;
    logic [CW-1:0]       r_cp_n, r_cp_i;
    logic                r_cp_front;

    logic [1:0] t_b, m_b, b_b;
    assign t_b = r_role[sbpq_pkg::ROLE_TOP];
    assign m_b = r_role[sbpq_pkg::ROLE_MID];
    assign b_b = r_role[sbpq_pkg::ROLE_BOT];

    // slide choice: merge smaller into larger
    logic                sl_front;
    logic [1:0]          sl_src, sl_dst;
    logic [CW-1:0]       sl_n;
    logic [CW:0]         sl_sum;
    logic [SLOT_BITS-1:0] sl_dbase;
    always_comb begin
        sl_front = r_cnt[b_b] <= r_cnt[m_b];
        sl_dst   = sl_front ? m_b : b_b;
        sl_src   = sl_front ? b_b : m_b;
        sl_n     = r_cnt[sl_src];
        sl_sum   = {1'b0, r_cnt[sl_dst]} + {1'b0, sl_n};
        sl_dbase = sl_front ? (r_head[sl_dst] - sl_n[SLOT_BITS-1:0])
                            : (r_head[sl_dst] + r_cnt[sl_dst][SLOT_BITS-1:0]);
    end

    // push target
    logic [1:0] pu_role, pu_b;
    logic       pu_full;
    always_comb begin
        priority if (!r_seen) begin
            pu_role = sbpq_pkg::ROLE_TOP;
        end else if ({1'b0, r_pri} + 7'd2 <= {1'b0, r_top}) begin
            pu_role = sbpq_pkg::ROLE_BOT;
        end else if ({1'b0, r_pri} + 7'd1 == {1'b0, r_top}) begin
            pu_role = sbpq_pkg::ROLE_MID;
        end else begin
            pu_role = sbpq_pkg::ROLE_TOP;
        end
        pu_b    = r_role[pu_role];
        pu_full = r_cnt[pu_b] == BCAP;
    end

    // pop source: bot fifo, mid lifo, top fifo
    logic [1:0]          po_b;
    logic                po_hit, po_tail;
    logic [SLOT_BITS-1:0] po_pos;
    always_comb begin
        po_hit  = 1'b1;
        po_tail = 1'b0;
        priority if (r_cnt[b_b] != '0) begin
            po_b = b_b;
        end else if (r_cnt[m_b] != '0) begin
            po_b    = m_b;
            po_tail = 1'b1;
        end else begin
            po_b   = t_b;
            po_hit = r_cnt[t_b] != '0;
        end
        po_pos = po_tail ? (r_head[po_b] + r_cnt[po_b][SLOT_BITS-1:0] - 1'b1)
                         : r_head[po_b];
    end

    // store
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [IW-1:0] m_wdata, m_rdata;
    always_comb begin
        if (i_cmd.copy_step) begin
            m_raddr = {r_cp_src, r_cp_sbase + r_cp_i[SLOT_BITS-1:0]};
            m_we    = r_cp_i != '0;
            m_waddr = {r_cp_dst, r_cp_dbase + r_cp_i[SLOT_BITS-1:0] - 1'b1};
            m_wdata = m_rdata;
        end else begin
            m_raddr = {po_b, po_pos};
            m_we    = i_cmd.push_do && !pu_full;
            m_waddr = {pu_b, r_head[pu_b] + r_cnt[pu_b][SLOT_BITS-1:0]};
            m_wdata = {r_pri, r_loc};
        end
    end

    sbpq_ram #(.WIDTH(IW), .DEPTH(3 << SLOT_BITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    logic [SW-1:0]       tot;
    logic [SW+TOT_PAD:0] tot_ext;
    assign tot     = {2'b00, r_cnt[0]} + {2'b00, r_cnt[1]} + {2'b00, r_cnt[2]};
    assign tot_ext = {{sbpq_pkg::TOT_W{1'b0}}, tot};

    always_comb begin
        o_stat.is_pop      = r_mode == sbpq_pkg::MODE_POP;
        o_stat.need_slide  = r_seen && (r_pri > r_top);
        o_stat.slide_ovf   = sl_n != '0 && sl_sum > {1'b0, BCAP};
        o_stat.slide_empty = sl_n == '0;
        o_stat.copy_done   = r_cp_i == r_cp_n;
        o_stat.pop_hit     = po_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
                r_role[k] <= 2'(k);
            end
            r_top  <= '0;
            r_seen <= 1'b0;
        end else begin
            if (i_cmd.push_do) begin
                if (!r_seen) begin
                    r_top  <= r_pri;
                    r_seen <= 1'b1;
                end
                if (!pu_full) begin
                    r_cnt[pu_b] <= r_cnt[pu_b] + 1'b1;
                end
            end
            if (i_cmd.slide_skip) begin
                r_role[sbpq_pkg::ROLE_TOP] <= sl_front ? b_b : m_b;
                r_role[sbpq_pkg::ROLE_MID] <= t_b;
                r_role[sbpq_pkg::ROLE_BOT] <= sl_front ? m_b : b_b;
                r_top <= r_top + 1'b1;
            end
            if (i_cmd.copy_step && o_stat.copy_done) begin
                if (r_cp_front) begin
                    r_head[r_cp_dst] <= r_cp_dbase;
                end
                r_cnt[r_cp_dst]  <= r_cnt[r_cp_dst] + r_cp_n;
                r_head[r_cp_src] <= '0;
                r_cnt[r_cp_src]  <= '0;
                r_role[sbpq_pkg::ROLE_TOP] <= r_cp_front ? b_b : m_b;
                r_role[sbpq_pkg::ROLE_MID] <= t_b;
                r_role[sbpq_pkg::ROLE_BOT] <= r_cp_front ? m_b : b_b;
                r_top <= r_top + 1'b1;
            end
            if (i_cmd.pop_do && po_hit) begin
                if (!po_tail) begin
                    r_head[po_b] <= r_head[po_b] + 1'b1;
                end
                r_cnt[po_b] <= r_cnt[po_b] - 1'b1;
            end
        end
    end

    // payload, slide copy and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= i_mode;
            r_pri        <= i_push_pri;
            r_loc        <= i_push_loc;
            r_res_valid  <= 1'b0;
            r_res_pri    <= '0;
            r_res_loc    <= '0;
            r_res_status <= sbpq_pkg::ST_OK;
        end
        if (i_cmd.push_do && pu_full) begin
            r_res_status <= sbpq_pkg::ST_FULL;
        end
        if (i_cmd.slide_fail) begin
            r_res_status <= sbpq_pkg::ST_OVF;
        end
        if (i_cmd.pop_do && !po_hit) begin
            r_res_status <= sbpq_pkg::ST_EMPTY;
        end
        if (i_cmd.pop_cap) begin
            r_res_valid <= 1'b1;
            r_res_pri   <= m_rdata[IW-1:LW];
            r_res_loc   <= m_rdata[LW-1:0];
        end
        if (i_cmd.slide_start) begin
            r_cp_src   <= sl_src;
            r_cp_dst   <= sl_dst;
            r_cp_sbase <= r_head[sl_src];
            r_cp_dbase <= sl_dbase;
            r_cp_n     <= sl_n;
            r_cp_front <= sl_front;
            r_cp_i     <= '0;
        end
        if (i_cmd.copy_step) begin
            r_cp_i <= r_cp_i + 1'b1;
        end
        if (i_cmd.emit) begin
            o_pop_valid   <= r_res_valid;
            o_pop_pri     <= r_res_pri;
            o_pop_loc     <= r_res_loc;
            o_status      <= r_res_status;
            o_total_count <= tot_ext[sbpq_pkg::TOT_W-1:0];
            o_queue_empty <= tot == '0;
        end
    end
endmodule

### tb/sv/sliding_bucket_priority_queue_test.sv
// ----------------------------------------------------------------------------
// sliding_bucket_priority_queue_test
// drives push and pop words into the queue with random gaps and stalls, keeps
// its own copy of the three buckets, and compares every result word field by
// field
// ----------------------------------------------------------------------------
module sliding_bucket_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB         = sbpq_pkg::SLOT_BITS;
    localparam int PW         = sbpq_pkg::PRI_W;
    localparam int LW         = sbpq_pkg::LOC_W;
    localparam int BCAP       = 1 << SB;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic                        pop_valid;
        logic [PW-1:0]               pop_pri;
        logic [LW-1:0]               pop_loc;
        logic [sbpq_pkg::STAT_W-1:0] status;
        logic [sbpq_pkg::TOT_W-1:0]  total_count;
        logic                        queue_empty;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    sbpq_in_if  req_if ();
    sbpq_out_if res_if ();

    sliding_bucket_priority_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // shadow copy of the queue
    logic [PW+LW-1:0] bucket_mem [3][BCAP];
    logic [SB-1:0]    bucket_head [3];
    int               bucket_cnt [3];
    logic [1:0]       role_of [3];
    logic [PW-1:0]    top_pri;
    logic             pri_seen;

    t_result result_q [$];
    bit      had_error;
    bit      quiet_phase;
    int      idle_cycles;

    function automatic int queue_total();
        return bucket_cnt[0] + bucket_cnt[1] + bucket_cnt[2];
    endfunction

    function automatic bit bucket_append(int b, logic [PW+LW-1:0] word_v);
        logic [SB-1:0] pos;
        if (bucket_cnt[b] >= BCAP) return 1'b0;
        pos = bucket_head[b] + SB'(bucket_cnt[b]);
        bucket_mem[b][pos] = word_v;
        bucket_cnt[b]++;
        return 1'b1;
    endfunction

    // move src into dst, in front of its items or behind them
    function automatic bit merge_buckets(int dst, int src, bit front);
        int n;
        logic [SB-1:0] base;
        n = bucket_cnt[src];
        if (n == 0) return 1'b1;
        if (bucket_cnt[dst] + n > BCAP) return 1'b0;
        base = front ? bucket_head[dst] - SB'(n)
                     : bucket_head[dst] + SB'(bucket_cnt[dst]);
        for (int i = 0; i < n; i++)
            bucket_mem[dst][base + SB'(i)] =
                bucket_mem[src][bucket_head[src] + SB'(i)];
        if (front) bucket_head[dst] = base;
        bucket_cnt[dst] += n;
        bucket_head[src] = '0;
        bucket_cnt[src]  = 0;
        return 1'b1;
    endfunction

    function automatic bit slide_window();
        logic [1:0] t, m, b;
        t = role_of[sbpq_pkg::ROLE_TOP];
        m = role_of[sbpq_pkg::ROLE_MID];
        b = role_of[sbpq_pkg::ROLE_BOT];
        if (bucket_cnt[b] <= bucket_cnt[m]) begin
            if (!merge_buckets(m, b, 1'b1)) return 1'b0;
            role_of[sbpq_pkg::ROLE_TOP] = b;
            role_of[sbpq_pkg::ROLE_MID] = t;
            role_of[sbpq_pkg::ROLE_BOT] = m;
        end else begin
            if (!merge_buckets(b, m, 1'b0)) return 1'b0;
            role_of[sbpq_pkg::ROLE_TOP] = m;
            role_of[sbpq_pkg::ROLE_MID] = t;
            role_of[sbpq_pkg::ROLE_BOT] = b;
        end
        top_pri = top_pri + 1'b1;
        return 1'b1;
    endfunction

    function automatic logic [sbpq_pkg::STAT_W-1:0] predict_push(logic [PW-1:0] p,
                                                                 logic [LW-1:0] loc);
        logic [1:0] role;
        if (!pri_seen) begin
            top_pri  = p;
            pri_seen = 1'b1;
            role     = sbpq_pkg::ROLE_TOP;
        end else if (int'(p) + 2 <= int'(top_pri)) begin
            role = sbpq_pkg::ROLE_BOT;
        end else if (int'(p) + 1 == int'(top_pri)) begin
            role = sbpq_pkg::ROLE_MID;
        end else begin
            while (p > top_pri)
                if (!slide_window()) return sbpq_pkg::ST_OVF;
            role = sbpq_pkg::ROLE_TOP;
        end
        return bucket_append(role_of[role], {p, loc}) ? sbpq_pkg::ST_OK
                                                      : sbpq_pkg::ST_FULL;
    endfunction

    function automatic t_result predict_result(logic mode, logic [PW-1:0] p,
                                               logic [LW-1:0] loc);
        t_result r;
        logic [1:0] b, m, t;
        logic [PW+LW-1:0] item;
        r = '0;
        b = role_of[sbpq_pkg::ROLE_BOT];
        m = role_of[sbpq_pkg::ROLE_MID];
        t = role_of[sbpq_pkg::ROLE_TOP];
        if (mode == sbpq_pkg::MODE_PUSH) begin
            r.status = predict_push(p, loc);
        end else if (bucket_cnt[b] > 0) begin
            // bot drains from its head
            item = bucket_mem[b][bucket_head[b]];
            bucket_head[b]++;
            bucket_cnt[b]--;
            r.pop_valid = 1'b1;
            {r.pop_pri, r.pop_loc} = item;
        end else if (bucket_cnt[m] > 0) begin
            // mid drains from its tail
            item = bucket_mem[m][bucket_head[m] + SB'(bucket_cnt[m] - 1)];
            bucket_cnt[m]--;
            r.pop_valid = 1'b1;
            {r.pop_pri, r.pop_loc} = item;
        end else if (bucket_cnt[t] > 0) begin
            item = bucket_mem[t][bucket_head[t]];
            bucket_head[t]++;
            bucket_cnt[t]--;
            r.pop_valid = 1'b1;
            {r.pop_pri, r.pop_loc} = item;
        end else begin
            r.status = sbpq_pkg::ST_EMPTY;
        end
        r.total_count = sbpq_pkg::TOT_W'(queue_total());
        r.queue_empty = (queue_total() == 0);
        return r;
    endfunction

    // mostly short gaps, a few long ones, none at all in quiet phases
    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // request side: fields change at the falling edge, accept seen at the
    // rising edge
    // ------------------------------------------------------------------
    task automatic send_word(logic mode, logic [PW-1:0] p, logic [LW-1:0] loc);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.mode     = mode;
        req_if.push_pri = p;
        req_if.push_loc = loc;
        forever begin
            @(posedge i_clk);
            if (req_if.ready) break;
            @(negedge i_clk);
        end
        result_q.push_back(predict_result(mode, p, loc));
    endtask

    task automatic push_word(logic [PW-1:0] p, logic [LW-1:0] loc);
        send_word(sbpq_pkg::MODE_PUSH, p, loc);
    endtask

    task automatic pop_word();
        send_word(sbpq_pkg::MODE_POP, PW'($urandom), $urandom);
    endtask

    task automatic drain_queue();
        while (queue_total() > 0) pop_word();
        pop_word();
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, compare at the rising edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (quiet_phase) begin
            res_if.ready <= 1'b1;
        end else begin
            res_if.ready <= (pick_gap() == 0);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (result_q.size() == 0) begin
                $error("result word with nothing expected");
                had_error = 1'b1;
            end else begin
                want = result_q.pop_front();
                if (res_if.pop_valid !== want.pop_valid) begin
                    $error("pop_valid: expected %0d, got %0d", want.pop_valid,
                           res_if.pop_valid);
                    had_error = 1'b1;
                end
                if (res_if.pop_pri !== want.pop_pri) begin
                    $error("pop_pri: expected %0d, got %0d", want.pop_pri, res_if.pop_pri);
                    had_error = 1'b1;
                end
                if (res_if.pop_loc !== want.pop_loc) begin
                    $error("pop_loc: expected %h, got %h", want.pop_loc, res_if.pop_loc);
                    had_error = 1'b1;
                end
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    had_error = 1'b1;
                end
                if (res_if.total_count !== want.total_count) begin
                    $error("total_count: expected %0d, got %0d", want.total_count,
                           res_if.total_count);
                    had_error = 1'b1;
                end
                if (res_if.queue_empty !== want.queue_empty) begin
                    $error("queue_empty: expected %0d, got %0d", want.queue_empty,
                           res_if.queue_empty);
                    had_error = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IDLE_LIMIT) begin
            $display("sliding_bucket_priority_queue_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty pop, first push, mid and bot placement, single and multi-step
    // slides with empty merges, then a full drain
    task automatic test_basic();
        pop_word();
        push_word(6'd20, 32'h0000_0000);
        push_word(6'd19, 32'hFFFF_FFFF);
        push_word(6'd18, 32'h1234_5678);
        push_word(6'd5,  32'h8765_4321);
        push_word(6'd20, 32'hA5A5_A5A5);
        push_word(6'd21, 32'h5A5A_5A5A);
        push_word(6'd24, 32'hDEAD_BEEF);
        push_word(6'd0,  32'h0000_0001);
        push_word(6'd23, 32'h8000_0000);
        drain_queue();
    endtask

    // mostly pushes around the top of the window, some slides, many pops
    task automatic test_random_traffic();
        int r;
        int hi;
        logic [PW-1:0] p;
        for (int i = 0; i < 360; i++) begin
            if (i % 80 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                pop_word();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 20)      p = top_pri;
                else if (r < 40) p = top_pri - (top_pri != 0);
                else if (r < 85) p = $urandom_range(0, top_pri);
                else begin
                    hi = int'(top_pri) + 3;
                    if (hi > 62) hi = 62;
                    p = $urandom_range(top_pri, hi);
                end
                push_word(p, $urandom);
            end
        end
        quiet_phase = 1'b0;
    endtask

    // highest priority closes the window, lowest sits far below it
    task automatic test_priority_extremes();
        push_word(6'd63, 32'h0000_0000);
        push_word(6'd0,  32'hFFFF_FFFF);
        push_word(6'd62, 32'hFFFF_0000);
        push_word(6'd63, 32'h0000_FFFF);
        drain_queue();
    endtask

    initial begin
        int settle;
        req_if.valid    = 1'b0;
        req_if.mode     = sbpq_pkg::MODE_PUSH;
        req_if.push_pri = '0;
        req_if.push_loc = '0;
        res_if.ready    = 1'b0;
        had_error       = 1'b0;
        quiet_phase     = 1'b0;
        idle_cycles     = 0;
        for (int b = 0; b < 3; b++) begin
            bucket_head[b] = '0;
            bucket_cnt[b]  = 0;
        end
        role_of[sbpq_pkg::ROLE_TOP] = 2'd0;
        role_of[sbpq_pkg::ROLE_MID] = 2'd1;
        role_of[sbpq_pkg::ROLE_BOT] = 2'd2;
        top_pri  = '0;
        pri_seen = 1'b0;

        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic();
        test_random_traffic();
        test_priority_extremes();

        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        settle = 20;
        repeat (settle) @(posedge i_clk);

        if (!had_error && result_q.size() == 0) begin
            $display("sliding_bucket_priority_queue_test: done, clean");
        end else begin
            $display("sliding_bucket_priority_queue_test: done, errors");
        end
        $finish;
    end
endmodule

### sim.f
rtl/sbpq_pkg.sv
rtl/sbpq_in_if.sv
rtl/sbpq_out_if.sv
rtl/sbpq_ram.sv
rtl/sbpq_ctrl.sv
rtl/sbpq_dp.sv
rtl/sliding_bucket_priority_queue.sv
tb/sv/sliding_bucket_priority_queue_test.sv
